// ===== rtl/core/assert_macros.svh =====
// shared assertion wrappers, clocked on clk and quiet during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define BAS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

`define BAS_ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

// ===== rtl/core/bas_pkg.sv =====
`default_nettype none

package bas_pkg;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_BEEP  = 2'd1,
        OP_STOP  = 2'd2,
        OP_ALARM = 2'd3
    } bas_op_t;

    localparam logic [1:0] CFG_ALARM_TONE = 2'd0;
    localparam logic [1:0] CFG_ALARM_ON   = 2'd1;
    localparam logic [1:0] CFG_ALARM_OFF  = 2'd2;

    localparam logic [15:0] ALARM_TONE_RESET = 16'd2000;
    localparam logic [15:0] ALARM_ON_RESET   = 16'd80;
    localparam logic [15:0] ALARM_OFF_RESET  = 16'd120;

    typedef struct packed {
        logic [15:0] alarm_tone_hz;
        logic [15:0] alarm_on_ms;
        logic [15:0] alarm_off_ms;
    } bas_cfg_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] tone_hz;
        logic [15:0] beep_ms;
        logic [7:0]  burst_count;
    } bas_cmd_t;

    typedef struct packed {
        logic [31:0] time_now;
        logic        beep_running;
        logic        beep_timed;
        logic [31:0] beep_deadline;
        logic [7:0]  bursts_wanted;
        logic [7:0]  bursts_done;
        logic [31:0] burst_deadline;
        logic        burst_phase_on;
        logic        drive_on;
        logic [15:0] drive_hz;
    } bas_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/bas_cmd_if.sv =====
`default_nettype none

interface bas_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [15:0] tone_hz;
    logic [15:0] beep_ms;
    logic [7:0]  burst_count;

    modport source (output valid, operation, tone_hz, beep_ms, burst_count, input ready);
    modport sink   (input valid, operation, tone_hz, beep_ms, burst_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bas_res_if.sv =====
`default_nettype none

interface bas_res_if;
    logic        valid;
    logic        ready;
    logic        sound_on;
    logic [15:0] sound_hz;
    logic        alarm_busy;

    modport source (output valid, sound_on, sound_hz, alarm_busy, input ready);
    modport sink   (input valid, sound_on, sound_hz, alarm_busy, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bas_update.sv =====
`default_nettype none

module bas_update (
    input  wire bas_pkg::bas_state_t cur,
    input  wire bas_pkg::bas_cfg_t   cfg,
    input  wire bas_pkg::bas_cmd_t   cmd,
    output bas_pkg::bas_state_t      nxt
);

    logic [31:0] now;
    logic        beep_due;
    logic        alarm_run;
    logic        burst_due;

    assign now       = cur.time_now + 32'd1;
    assign beep_due  = cur.beep_running && cur.beep_timed && (now >= cur.beep_deadline)
                       && (cur.bursts_wanted == 8'd0);
    assign alarm_run = (cur.bursts_wanted != 8'd0) && (cur.bursts_done < cur.bursts_wanted);
    assign burst_due = now >= cur.burst_deadline;

    always_comb
    begin
        nxt = cur;
        unique case (cmd.operation)
            bas_pkg::OP_TICK:
            begin
                nxt.time_now = now;
                if (beep_due || (!alarm_run && cur.bursts_wanted != 8'd0))
                begin
                    nxt.drive_on      = 1'b0;
                    nxt.beep_running  = 1'b0;
                    nxt.beep_timed    = 1'b0;
                    nxt.beep_deadline = 32'd0;
                    nxt.bursts_wanted = 8'd0;
                end
                else if (alarm_run && burst_due)
                begin
                    if (cur.burst_phase_on)
                    begin
                        nxt.drive_hz       = cfg.alarm_tone_hz;
                        nxt.drive_on       = 1'b1;
                        nxt.burst_deadline = now + {16'd0, cfg.alarm_on_ms};
                    end
                    else
                    begin
                        nxt.drive_on       = 1'b0;
                        nxt.burst_deadline = now + {16'd0, cfg.alarm_off_ms};
                        nxt.bursts_done    = cur.bursts_done + 8'd1;
                    end
                    nxt.burst_phase_on = !cur.burst_phase_on;
                end
            end
            bas_pkg::OP_BEEP:
            begin
                nxt.drive_hz      = cmd.tone_hz;
                nxt.drive_on      = 1'b1;
                nxt.beep_running  = 1'b1;
                nxt.beep_timed    = cmd.beep_ms != 16'd0;
                // an untimed beep carries no deadline
                nxt.beep_deadline = (cmd.beep_ms != 16'd0)
                                    ? cur.time_now + {16'd0, cmd.beep_ms} : 32'd0;
                nxt.bursts_wanted = 8'd0;
            end
            bas_pkg::OP_STOP:
            begin
                nxt.drive_on      = 1'b0;
                nxt.beep_running  = 1'b0;
                nxt.beep_timed    = 1'b0;
                nxt.beep_deadline = 32'd0;
                nxt.bursts_wanted = 8'd0;
            end
            bas_pkg::OP_ALARM:
            begin
                nxt.bursts_wanted  = cmd.burst_count;
                nxt.bursts_done    = 8'd0;
                nxt.burst_deadline = cur.time_now;
                nxt.burst_phase_on = 1'b1;
                nxt.drive_hz       = cfg.alarm_tone_hz;
                nxt.drive_on       = 1'b1;
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/beep_and_alarm_sequencer.sv =====
`default_nettype none
`include "assert_macros.svh"

// Buzzer sequencer: each word on cmd is a 1 ms tick or a beep, stop or alarm
// command, and each gives exactly one word on res with the buzzer drive after
// it. One word is taken every clock unless res stalls; a word passes the input
// register, then the result register, and the sustained rate of one per cycle
// is set by the loop from the state registers through the update logic back to them.
// The user writes the alarm registers via cfg_wr_en / cfg_index / cfg_data only
// while no word is in flight, which the block does not enforce; index 3 is ignored.
module beep_and_alarm_sequencer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    bas_cmd_if.sink          cmd,
    bas_res_if.source        res
);

    bas_pkg::bas_cfg_t   cfg_reg;
    bas_pkg::bas_state_t state_reg;
    bas_pkg::bas_state_t state_next;
    bas_pkg::bas_cmd_t   in_word_reg;
    logic                in_valid_reg;
    logic                res_valid_reg;
    logic                res_sound_on_reg;
    logic [15:0]         res_sound_hz_reg;
    logic                res_alarm_busy_reg;
    logic                fire;

    assign fire      = in_valid_reg && (!res_valid_reg || res.ready);
    assign cmd.ready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.alarm_tone_hz <= bas_pkg::ALARM_TONE_RESET;
            cfg_reg.alarm_on_ms   <= bas_pkg::ALARM_ON_RESET;
            cfg_reg.alarm_off_ms  <= bas_pkg::ALARM_OFF_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                bas_pkg::CFG_ALARM_TONE: cfg_reg.alarm_tone_hz <= cfg_data;
                bas_pkg::CFG_ALARM_ON:   cfg_reg.alarm_on_ms   <= cfg_data;
                bas_pkg::CFG_ALARM_OFF:  cfg_reg.alarm_off_ms  <= cfg_data;
                default:                 cfg_reg <= cfg_reg;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            in_valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            in_word_reg.operation   <= cmd.operation;
            in_word_reg.tone_hz     <= cmd.tone_hz;
            in_word_reg.beep_ms     <= cmd.beep_ms;
            in_word_reg.burst_count <= cmd.burst_count;
        end
    end

    bas_update u_update (
        .cur (state_reg),
        .cfg (cfg_reg),
        .cmd (in_word_reg),
        .nxt (state_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (fire)
        begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_sound_on_reg   <= state_next.drive_on;
            res_sound_hz_reg   <= state_next.drive_hz;
            res_alarm_busy_reg <= (state_next.bursts_wanted != 8'd0)
                                  && (state_next.bursts_done < state_next.bursts_wanted);
        end
    end

    assign res.valid      = res_valid_reg;
    assign res.sound_on   = res_sound_on_reg;
    assign res.sound_hz   = res_sound_hz_reg;
    assign res.alarm_busy = res_alarm_busy_reg;

    `BAS_ASSERT(a_burst_count_bound, (state_reg.bursts_wanted != 8'd0) |-> (state_reg.bursts_done <= state_reg.bursts_wanted), "bursts done beyond bursts wanted")
    `BAS_ASSERT_NEVER(a_timed_needs_beep, state_reg.beep_timed && !state_reg.beep_running, "timed beep without a running beep")
    `BAS_ASSERT(a_time_on_tick_only, (fire && (in_word_reg.operation != bas_pkg::OP_TICK)) |=> $stable(state_reg.time_now), "time moved on a command")

endmodule

`default_nettype wire
